FILE: sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// shared constants for the 128-bit montgomery modular arithmetic unit
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int WORD_W  = 64;
   localparam int VAL_W   = 128;
   localparam int ACC_W   = 194;
   localparam int T_W     = ACC_W - WORD_W;

   localparam int MUL_LAT = 3;
   localparam int RHO_LAT = 2;
   localparam int RND_LAT = MUL_LAT + RHO_LAT + MUL_LAT;
   localparam int ALT_DLY = 2 * RND_LAT;
   localparam int PIPE_LAT = ALT_DLY + 2;

   localparam logic [1:0] MODE_MUL = 2'd0;
   localparam logic [1:0] MODE_SQR = 2'd1;
   localparam logic [1:0] MODE_ADD = 2'd2;
   localparam logic [1:0] MODE_SUB = 2'd3;

   localparam logic [1:0] CSR_MOD_LOW  = 2'd0;
   localparam logic [1:0] CSR_MOD_HIGH = 2'd1;
   localparam logic [1:0] CSR_NEG_INV  = 2'd2;

endpackage

FILE: sv/montgomery_mod_arith_128.sv
// ----------------------------------------------------------------------------
// montgomery_mod_arith_128
// pipelined montgomery multiply, square, modular add and subtract, 128 bits
// ----------------------------------------------------------------------------
// usage
//   csr port: write csr_data to register csr_index while csr_write_enable is high
//   (0 modulus low, 1 modulus high, 2 negated inverse); writes take effect at once
//   and must be made only while no word is in flight; the block does not enforce it
//   request: a word is taken at each clock edge with start high and busy low;
//   busy stays low, so a word may be issued on every cycle
//   response: rsp_valid strobes for one cycle with the result words; the
//   receiver cannot hold results off and none is needed
//   every mode passes the entry register, both reduction rounds and the output register;
//   throughput one word per cycle, set by the fully pipelined 32x32 multiplier
//   array (four 128x64 multiply-accumulate units and two rho units)
//   reset: synchronous, clears every valid bit and loads the reset modulus
//   (one) and reset inverse; words in flight are dropped
// ----------------------------------------------------------------------------
module montgomery_mod_arith_128
   import mma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [WORD_W-1:0] req_first_low,
   input  logic [WORD_W-1:0] req_first_high,
   input  logic [WORD_W-1:0] req_second_low,
   input  logic [WORD_W-1:0] req_second_high,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_result_low,
   output logic [WORD_W-1:0] rsp_result_high,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   // configuration registers
   logic [WORD_W-1:0] mod_low_ff;
   logic [WORD_W-1:0] mod_high_ff;
   logic [WORD_W-1:0] neg_inv_ff;
   logic [VAL_W-1:0]  modulus;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_low_ff  <= 64'd1;
         mod_high_ff <= 64'd0;
         neg_inv_ff  <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MOD_LOW:  mod_low_ff  <= csr_data;
            CSR_MOD_HIGH: mod_high_ff <= csr_data;
            CSR_NEG_INV:  neg_inv_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign modulus = {mod_high_ff, mod_low_ff};
   assign busy    = 1'b0;

   // entry stage: operand select and the add / subtract raw value
   logic [VAL_W-1:0] req_a;
   logic [VAL_W-1:0] req_b;
   logic [VAL_W:0]   alt_in;
   logic             s0_valid_ff;
   logic [1:0]       s0_mode_ff;
   logic [VAL_W-1:0] s0_a_ff;
   logic [VAL_W-1:0] s0_b_ff;
   logic [VAL_W:0]   s0_alt_ff;

   assign req_a = {req_first_high, req_first_low};
   // square reuses the first operand as the second
   assign req_b = (req_mode == MODE_SQR) ? req_a : {req_second_high, req_second_low};
   // add keeps its carry in the top bit, subtract its borrow
   assign alt_in = (req_mode == MODE_SUB) ? ({1'b0, req_a} - {1'b0, req_b})
                                          : ({1'b0, req_a} + {1'b0, req_b});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_mode_ff <= req_mode;
      s0_a_ff    <= req_a;
      s0_b_ff    <= req_b;
      s0_alt_ff  <= alt_in;
   end

   // side data delay lines: a and b1 matched to round one, add / subtract value and mode to both rounds
   logic [VAL_W-1:0]  a_dly_ff  [RND_LAT];
   logic [WORD_W-1:0] b1_dly_ff [RND_LAT];
   logic [VAL_W:0]    alt_dly_ff  [ALT_DLY];
   logic [1:0]        mode_dly_ff [ALT_DLY];

   always_ff @(posedge clock) begin
      a_dly_ff[0]  <= s0_a_ff;
      b1_dly_ff[0] <= s0_b_ff[VAL_W-1:WORD_W];
      for (int k = 1; k < RND_LAT; k++) begin
         a_dly_ff[k]  <= a_dly_ff[k-1];
         b1_dly_ff[k] <= b1_dly_ff[k-1];
      end
      alt_dly_ff[0]  <= s0_alt_ff;
      mode_dly_ff[0] <= s0_mode_ff;
      for (int k = 1; k < ALT_DLY; k++) begin
         alt_dly_ff[k]  <= alt_dly_ff[k-1];
         mode_dly_ff[k] <= mode_dly_ff[k-1];
      end
   end

   // round one: acc = a*b0, m = acc*rho, t1 = (acc + m*n) >> 64
   logic             r1a_valid;
   logic [ACC_W-1:0] r1a_acc;
   logic             r1m_valid;
   logic [WORD_W-1:0] r1_m;
   logic [ACC_W-1:0] r1_acc_dly_ff [RHO_LAT];
   logic             r1b_valid;
   logic [ACC_W-1:0] r1b_acc;

   mma_mul u_mul_r1a (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (s0_valid_ff),
      .x         (s0_a_ff),
      .y         (s0_b_ff[WORD_W-1:0]),
      .addend    ('0),
      .valid_out (r1a_valid),
      .prod      (r1a_acc)
   );

   mma_rho u_rho_r1 (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r1a_valid),
      .low       (r1a_acc[WORD_W-1:0]),
      .rho       (neg_inv_ff),
      .valid_out (r1m_valid),
      .m         (r1_m)
   );

   always_ff @(posedge clock) begin
      r1_acc_dly_ff[0] <= r1a_acc;
      for (int k = 1; k < RHO_LAT; k++) begin
         r1_acc_dly_ff[k] <= r1_acc_dly_ff[k-1];
      end
   end

   mma_mul u_mul_r1b (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r1m_valid),
      .x         (modulus),
      .y         (r1_m),
      .addend    (r1_acc_dly_ff[RHO_LAT-1]),
      .valid_out (r1b_valid),
      .prod      (r1b_acc)
   );

   // round two: acc = t1 + a*b1, then the same reduction
   logic             r2a_valid;
   logic [ACC_W-1:0] r2a_acc;
   logic             r2m_valid;
   logic [WORD_W-1:0] r2_m;
   logic [ACC_W-1:0] r2_acc_dly_ff [RHO_LAT];
   logic             r2b_valid;
   logic [ACC_W-1:0] r2b_acc;

   mma_mul u_mul_r2a (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r1b_valid),
      .x         (a_dly_ff[RND_LAT-1]),
      .y         (b1_dly_ff[RND_LAT-1]),
      .addend    (ACC_W'(r1b_acc[ACC_W-1:WORD_W])),
      .valid_out (r2a_valid),
      .prod      (r2a_acc)
   );

   mma_rho u_rho_r2 (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r2a_valid),
      .low       (r2a_acc[WORD_W-1:0]),
      .rho       (neg_inv_ff),
      .valid_out (r2m_valid),
      .m         (r2_m)
   );

   always_ff @(posedge clock) begin
      r2_acc_dly_ff[0] <= r2a_acc;
      for (int k = 1; k < RHO_LAT; k++) begin
         r2_acc_dly_ff[k] <= r2_acc_dly_ff[k-1];
      end
   end

   mma_mul u_mul_r2b (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r2m_valid),
      .x         (modulus),
      .y         (r2_m),
      .addend    (r2_acc_dly_ff[RHO_LAT-1]),
      .valid_out (r2b_valid),
      .prod      (r2b_acc)
   );

   // final correction: one conditional subtract of n, or add-back for subtract
   logic [1:0]       fin_mode;
   logic [T_W-1:0]   fin_x;
   logic [T_W-1:0]   fin_n;
   logic [T_W-1:0]   fin_diff;
   logic [VAL_W-1:0] fin_sum;
   logic [VAL_W-1:0] res_in;
   logic             out_valid_ff;
   logic [VAL_W-1:0] res_ff;

   assign fin_mode = mode_dly_ff[ALT_DLY-1];
   assign fin_x    = (fin_mode[1] == 1'b0) ? r2b_acc[ACC_W-1:WORD_W]
                                           : T_W'(alt_dly_ff[ALT_DLY-1]);
   assign fin_n    = T_W'(modulus);
   assign fin_diff = fin_x - fin_n;
   assign fin_sum  = fin_x[VAL_W-1:0] + modulus;

   always_comb begin
      unique case (fin_mode)
         MODE_SUB: res_in = fin_x[VAL_W] ? fin_sum : fin_x[VAL_W-1:0];
         MODE_MUL,
         MODE_SQR,
         MODE_ADD: res_in = (fin_x >= fin_n) ? fin_diff[VAL_W-1:0] : fin_x[VAL_W-1:0];
         default:  res_in = fin_x[VAL_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= r2b_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_low  = res_ff[WORD_W-1:0];
   assign rsp_result_high = res_ff[VAL_W-1:WORD_W];

`ifndef SYNTHESIS
   a_top_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##18 rsp_valid)
      else $error("word accepted but no response after pipeline latency");
   a_top_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 18))
      else $error("response without a matching request");
   a_round_align: assert property (@(posedge clock) disable iff (reset)
      r1b_valid |-> $past(s0_valid_ff, RND_LAT))
      else $error("round one out of step with operand delay line");
`endif

endmodule

FILE: sv/mma_mul.sv
// ----------------------------------------------------------------------------
// mma_mul
// pipelined 128x64 multiply-accumulate built from 32x32 partial products
// ----------------------------------------------------------------------------
module mma_mul
   import mma_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  logic [VAL_W-1:0] x,
   input  logic [WORD_W-1:0] y,
   input  logic [ACC_W-1:0] addend,
   output logic             valid_out,
   output logic [ACC_W-1:0] prod
);

   logic [MUL_LAT-1:0] valid_ff;
   logic [63:0]        part_ff [4][2];
   logic [159:0]       row_ff [2];
   logic [ACC_W-1:0]   add1_ff;
   logic [ACC_W-1:0]   add2_ff;
   logic [ACC_W-1:0]   prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[MUL_LAT-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      // partial products, one 32x32 each
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 2; j++) begin
            part_ff[i][j] <= 64'(x[32*i +: 32]) * 64'(y[32*j +: 32]);
         end
      end
      add1_ff <= addend;
      // fold each row: even lanes do not overlap, odd lanes sit 32 bits up
      for (int j = 0; j < 2; j++) begin
         row_ff[j] <= {32'd0, part_ff[2][j], part_ff[0][j]}
                    + {part_ff[3][j], part_ff[1][j], 32'd0};
      end
      add2_ff <= add1_ff;
      prod_ff <= add2_ff + ACC_W'(row_ff[0]) + (ACC_W'(row_ff[1]) << 32);
   end

   assign valid_out = valid_ff[MUL_LAT-1];
   assign prod      = prod_ff;

`ifndef SYNTHESIS
   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      valid_in |-> ##3 valid_out)
      else $error("mma_mul lost a word");
   a_mul_origin: assert property (@(posedge clock) disable iff (reset)
      valid_out |-> $past(valid_in, 3))
      else $error("mma_mul invented a word");
`endif

endmodule

FILE: sv/mma_rho.sv
// ----------------------------------------------------------------------------
// mma_rho
// low 64 bits of word times rho, two pipeline stages
// ----------------------------------------------------------------------------
module mma_rho
   import mma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  logic [WORD_W-1:0] low,
   input  logic [WORD_W-1:0] rho,
   output logic              valid_out,
   output logic [WORD_W-1:0] m
);

   logic [RHO_LAT-1:0] valid_ff;
   logic [63:0]        p00_ff;
   logic [31:0]        p01_ff;
   logic [31:0]        p10_ff;
   logic [63:0]        m_ff;
   logic [31:0]        cross_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[RHO_LAT-2:0], valid_in};
      end
   end

   assign cross_sum = p01_ff + p10_ff;

   always_ff @(posedge clock) begin
      p00_ff <= 64'(low[31:0]) * 64'(rho[31:0]);
      p01_ff <= low[31:0] * rho[63:32];
      p10_ff <= low[63:32] * rho[31:0];
      m_ff   <= p00_ff + {cross_sum, 32'd0};
   end

   assign valid_out = valid_ff[RHO_LAT-1];
   assign m         = m_ff;

`ifndef SYNTHESIS
   a_rho_latency: assert property (@(posedge clock) disable iff (reset)
      valid_in |-> ##2 valid_out)
      else $error("mma_rho lost a word");
`endif

endmodule
